>>> sv/resel_pkg.sv
// ----------------------------------------------------------------------------
// resel_pkg: shared types and constants of the rectangle edge snap selector
// Widths, item kinds, stream packing and the stored rectangle record.
// ----------------------------------------------------------------------------
package resel_pkg;

	localparam int MAX_ENTRIES = 10;
	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

	localparam int COORD_W = 16;
	localparam int SIZE_W  = 15;
	localparam int DEPTH_W = 8;
	localparam int SNAP_W  = 12;
	localparam int DIST_W  = 17;
	localparam int DIFF_W  = 18;

	localparam logic [SNAP_W-1:0] SNAP_RESET = 12'd10;

	localparam int KIND_W = 2;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
	localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

	localparam int S_TDATA_W = 104;
	localparam int M_TDATA_W = 72;
	localparam int M_USED_W  = 2 * COORD_W + 2 * SIZE_W + DEPTH_W;

	typedef struct packed {
		logic [DEPTH_W-1:0]        depth;
		logic [SIZE_W-1:0]         height;
		logic [SIZE_W-1:0]         width;
		logic signed [COORD_W-1:0] top;
		logic signed [COORD_W-1:0] left;
	} entry_t;

endpackage

>>> sv/rectangle_edge_snap_select_core.sv
// ----------------------------------------------------------------------------
// rectangle_edge_snap_select_core: rectangle edge snap selector
// Holds a table of rectangles and picks the one a cursor snaps to.
// ----------------------------------------------------------------------------
// Input beats arrive on s_*: tuser is the kind (clear, append, query), tdata
// carries the rectangle for an append and the cursor for a query. Clear and
// append give no output beat. A query scans the stored rectangles through
// one shared distance unit, one entry a cycle, behind a table read register
// and a distance register, and holds s_tready low from its beat until its
// answer is loaded into the output register; the answer beat comes up as
// s_tready returns.
// The answer is one beat on m_*: tuser is the snapped flag, tdata the winning
// box and depth, all zero when nothing snaps. The output register lets the
// next item in while an answer waits; a query that finishes while the old
// answer is still stalled waits for m_tready before it loads.
// cfg_wr_en writes snap_distance from cfg_wr_data; zero is ignored.
// Reset empties the table and sets snap_distance to 10; table contents are
// not cleared, only entries below the fill count are ever read.
// ----------------------------------------------------------------------------
module rectangle_edge_snap_select_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// rect_left, rect_top, rect_width, rect_height, rect_depth, point_x, point_y
	input  logic [resel_pkg::S_TDATA_W-1:0]   s_tdata,
	// kind
	input  logic [resel_pkg::KIND_W-1:0]      s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// snap_left, snap_top, snap_width, snap_height, snap_depth
	output logic [resel_pkg::M_TDATA_W-1:0]   m_tdata,
	// snapped
	output logic                              m_tuser,
	input  logic                              cfg_wr_en,
	input  logic [resel_pkg::SNAP_W-1:0]      cfg_wr_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	localparam int PX_LO = 2 * resel_pkg::COORD_W + 2 * resel_pkg::SIZE_W + resel_pkg::DEPTH_W;
	localparam int PY_LO = PX_LO + resel_pkg::COORD_W;

	logic [1:0]                              state_q;
	logic [resel_pkg::CNT_W-1:0]             ent_cnt_q;
	logic [resel_pkg::CNT_W-1:0]             issue_q;
	logic [resel_pkg::SNAP_W-1:0]            snap_q;
	logic signed [resel_pkg::COORD_W-1:0]    px_q;
	logic signed [resel_pkg::COORD_W-1:0]    py_q;
	resel_pkg::entry_t                       tbl_mem [resel_pkg::MAX_ENTRIES];
	resel_pkg::entry_t                       ent_s1;
	resel_pkg::entry_t                       ent_s2;
	logic                                    v_s1;
	logic                                    v_s2;
	logic [resel_pkg::DIST_W-1:0]            dist_s2;
	logic [resel_pkg::DIST_W-1:0]            scan_dist;
	logic                                    found_q;
	logic [resel_pkg::DIST_W-1:0]            best_dist_q;
	resel_pkg::entry_t                       best_q;
	logic                                    m_tvalid_q;
	logic [resel_pkg::M_TDATA_W-1:0]         m_tdata_q;
	logic                                    m_tuser_q;

	resel_pkg::entry_t                       in_ent;
	logic                                    s_fire;
	logic                                    do_append;
	logic                                    issue_more;
	logic                                    take;
	logic                                    out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign s_fire   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign out_free = !m_tvalid_q || m_tready;

	assign in_ent     = resel_pkg::entry_t'(s_tdata[resel_pkg::M_USED_W-1:0]);
	assign do_append  = s_fire && (s_tuser == resel_pkg::KIND_APPEND) &&
		(ent_cnt_q < resel_pkg::CNT_W'(resel_pkg::MAX_ENTRIES));
	assign issue_more = (state_q == ST_SCAN) && (issue_q < ent_cnt_q);

	assign take = v_s2 && ({{(resel_pkg::DIST_W - resel_pkg::SNAP_W){1'b0}}, snap_q} >= dist_s2) &&
		(!found_q || dist_s2 < best_dist_q ||
		(dist_s2 == best_dist_q && ent_s2.depth > best_q.depth));

	resel_dist u_dist (
		.px       (px_q),
		.py       (py_q),
		.ent      (ent_s1),
		.min_dist (scan_dist)
	);

	// table memory
	always_ff @(posedge clk) begin
		if (do_append) begin
			tbl_mem[ent_cnt_q[resel_pkg::IDX_W-1:0]] <= in_ent;
		end
		if (issue_more) begin
			ent_s1 <= tbl_mem[issue_q[resel_pkg::IDX_W-1:0]];
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (s_fire) begin
			px_q <= s_tdata[PX_LO +: resel_pkg::COORD_W];
			py_q <= s_tdata[PY_LO +: resel_pkg::COORD_W];
		end
		if (v_s1) begin
			ent_s2  <= ent_s1;
			dist_s2 <= scan_dist;
		end
		if (take) begin
			best_dist_q <= dist_s2;
			best_q      <= ent_s2;
		end
		if (state_q == ST_DONE && out_free) begin
			m_tuser_q <= found_q;
			m_tdata_q <= found_q ?
				resel_pkg::M_TDATA_W'(best_q) : '0;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ent_cnt_q  <= '0;
			issue_q    <= '0;
			snap_q     <= resel_pkg::SNAP_RESET;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			found_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_wr_en && cfg_wr_data != '0) begin
				snap_q <= cfg_wr_data;
			end
			if (state_q == ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			v_s1 <= issue_more;
			v_s2 <= v_s1;
			if (take) begin
				found_q <= 1'b1;
			end
			if (do_append) begin
				ent_cnt_q <= ent_cnt_q + 1'b1;
			end
			if (issue_more) begin
				issue_q <= issue_q + 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_fire && s_tuser == resel_pkg::KIND_CLEAR) begin
						ent_cnt_q <= '0;
					end
					if (s_fire && s_tuser == resel_pkg::KIND_QUERY) begin
						issue_q <= '0;
						found_q <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (!issue_more && !v_s1 && !v_s2) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		ent_cnt_q <= resel_pkg::CNT_W'(resel_pkg::MAX_ENTRIES))
		else $error("table fill count beyond capacity");

	a_ready_idle_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (!v_s1 && !v_s2))
		else $error("scan pipeline busy while taking input");

	a_nosnap_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata == '0))
		else $error("unsnapped answer carries a box");

	a_snap_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		snap_q != '0)
		else $error("snap distance is zero");

	a_query_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> (m_tvalid && s_tready))
		else $error("finished query did not present its answer");

endmodule

>>> sv/resel_dist.sv
// ----------------------------------------------------------------------------
// resel_dist: edge distance unit
// Smallest distance from a point to the left, right, top and bottom edge lines of one rectangle,
// zero when the point lies inside the box or on its border.
// ----------------------------------------------------------------------------
module resel_dist (
	input  logic signed [resel_pkg::COORD_W-1:0] px,
	input  logic signed [resel_pkg::COORD_W-1:0] py,
	input  resel_pkg::entry_t                    ent,
	output logic [resel_pkg::DIST_W-1:0]         min_dist
);

	logic signed [resel_pkg::DIFF_W-1:0] px_e;
	logic signed [resel_pkg::DIFF_W-1:0] py_e;
	logic signed [resel_pkg::DIFF_W-1:0] l_e;
	logic signed [resel_pkg::DIFF_W-1:0] t_e;
	logic signed [resel_pkg::DIFF_W-1:0] r_e;
	logic signed [resel_pkg::DIFF_W-1:0] b_e;
	logic signed [resel_pkg::DIFF_W-1:0] dl;
	logic signed [resel_pkg::DIFF_W-1:0] dr;
	logic signed [resel_pkg::DIFF_W-1:0] dt;
	logic signed [resel_pkg::DIFF_W-1:0] db;
	logic [resel_pkg::DIST_W-1:0]        al;
	logic [resel_pkg::DIST_W-1:0]        ar;
	logic [resel_pkg::DIST_W-1:0]        at;
	logic [resel_pkg::DIST_W-1:0]        ab;
	logic [resel_pkg::DIST_W-1:0]        mx;
	logic [resel_pkg::DIST_W-1:0]        my;
	logic                                in_box;

	function automatic logic [resel_pkg::DIST_W-1:0] mag(
		input logic signed [resel_pkg::DIFF_W-1:0] v
	);
		logic signed [resel_pkg::DIFF_W-1:0] n;
		n = -v;
		return v[resel_pkg::DIFF_W-1] ? n[resel_pkg::DIST_W-1:0] : v[resel_pkg::DIST_W-1:0];
	endfunction

	always_comb begin
		px_e = resel_pkg::DIFF_W'(px);
		py_e = resel_pkg::DIFF_W'(py);
		l_e  = resel_pkg::DIFF_W'(ent.left);
		t_e  = resel_pkg::DIFF_W'(ent.top);
		r_e  = l_e + $signed({3'b000, ent.width});
		b_e  = t_e + $signed({3'b000, ent.height});
		dl   = px_e - l_e;
		dr   = px_e - r_e;
		dt   = py_e - t_e;
		db   = py_e - b_e;
		al   = mag(dl);
		ar   = mag(dr);
		at   = mag(dt);
		ab   = mag(db);
		mx   = (al < ar) ? al : ar;
		my   = (at < ab) ? at : ab;
		// on or inside the box: left/top diffs non-negative, right/bottom non-positive
		in_box = !dl[resel_pkg::DIFF_W-1] && (dr[resel_pkg::DIFF_W-1] || dr == '0) &&
			!dt[resel_pkg::DIFF_W-1] && (db[resel_pkg::DIFF_W-1] || db == '0);
		min_dist = in_box ? '0 : ((mx < my) ? mx : my);
	end

endmodule

>>> bench/rectangle_edge_snap_select_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rectangle_edge_snap_select_core_tb: self-checking bench for the snap selector
// Drives clear, append, query and unused-kind beats with random stalls on both streams,
// predicts each query answer from a private copy of the rectangle table and
// the snap distance, and checks every output beat field by field in order.
// ----------------------------------------------------------------------------
module rectangle_edge_snap_select_core_tb;

	localparam logic [resel_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

	typedef struct packed {
		logic              snapped;
		resel_pkg::entry_t box;
	} snap_answer_t;

	class snap_scoreboard;
		resel_pkg::entry_t            table_q[resel_pkg::MAX_ENTRIES];
		int                           fill;
		logic [resel_pkg::SNAP_W-1:0] snap_dist;
		snap_answer_t                 expected_answers[$];
		int                           errors;
		int                           answers;
		int                           snapped_answers;

		function new();
			fill = 0;
			snap_dist = resel_pkg::SNAP_RESET;
			errors = 0;
			answers = 0;
			snapped_answers = 0;
		endfunction

		function void write_snap(logic [resel_pkg::SNAP_W-1:0] v);
			if (v != '0) begin
				snap_dist = v;
			end
		endfunction

		function int gap(int a, int b);
			return (a >= b) ? a - b : b - a;
		endfunction

		function snap_answer_t predict_snap(int px, int py);
			snap_answer_t ans;
			int best;
			int l, t, r, b, d;
			ans = '0;
			best = 0;
			for (int i = 0; i < fill; i++) begin
				l = table_q[i].left;
				t = table_q[i].top;
				r = l + int'(table_q[i].width);
				b = t + int'(table_q[i].height);
				d = gap(px, l);
				if (gap(px, r) < d) d = gap(px, r);
				if (gap(py, t) < d) d = gap(py, t);
				if (gap(py, b) < d) d = gap(py, b);
				if (px >= l && px <= r && py >= t && py <= b) d = 0;
				if (d <= int'(snap_dist)) begin
					if (!ans.snapped || d < best ||
						(d == best && table_q[i].depth > ans.box.depth)) begin
						ans.snapped = 1'b1;
						ans.box = table_q[i];
						best = d;
					end
				end
			end
			return ans;
		endfunction

		function void note_item(logic [resel_pkg::KIND_W-1:0] kind,
			logic [resel_pkg::S_TDATA_W-1:0] data);
			int px;
			int py;
			px = $signed(data[85:70]);
			py = $signed(data[101:86]);
			case (kind)
				resel_pkg::KIND_CLEAR: fill = 0;
				resel_pkg::KIND_APPEND: begin
					if (fill < resel_pkg::MAX_ENTRIES) begin
						table_q[fill] = data[69:0];
						fill++;
					end
				end
				resel_pkg::KIND_QUERY: expected_answers.push_back(predict_snap(px, py));
				default: ;
			endcase
		endfunction

		function void report(string name, int exp_v, int act_v);
			if (exp_v != act_v) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, actual %0d",
					$time, name, exp_v, act_v);
			end
		endfunction

		function void check_answer(logic snapped, logic [resel_pkg::M_TDATA_W-1:0] data);
			snap_answer_t want;
			resel_pkg::entry_t got;
			got = data[69:0];
			answers++;
			if (expected_answers.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat, expected none, actual snapped %0d left %0d",
					$time, snapped, got.left);
				return;
			end
			want = expected_answers.pop_front();
			if (snapped) snapped_answers++;
			report("snapped", int'(want.snapped), int'(snapped));
			report("snap_left", int'(want.box.left), int'(got.left));
			report("snap_top", int'(want.box.top), int'(got.top));
			report("snap_width", int'(want.box.width), int'(got.width));
			report("snap_height", int'(want.box.height), int'(got.height));
			report("snap_depth", int'(want.box.depth), int'(got.depth));
		endfunction
	endclass

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              s_tvalid = 1'b0;
	logic                              s_tready;
	logic [resel_pkg::S_TDATA_W-1:0]   s_tdata = '0;
	logic [resel_pkg::KIND_W-1:0]      s_tuser = resel_pkg::KIND_CLEAR;
	logic                              m_tvalid;
	logic                              m_tready = 1'b0;
	logic [resel_pkg::M_TDATA_W-1:0]   m_tdata;
	logic                              m_tuser;
	logic                              cfg_wr_en = 1'b0;
	logic [resel_pkg::SNAP_W-1:0]      cfg_wr_data = '0;

	snap_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int recv_hold = 0;
	int live_items = 0;
	int query_count = 0;
	int snap_writes = 0;

	rectangle_edge_snap_select_core DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver stalls, with an optional long hold-off
	always @(posedge clk) begin
		if (recv_hold > 0) begin
			m_tready <= 1'b0;
			recv_hold <= recv_hold - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_answer(m_tuser, m_tdata);
		end
	end

	function resel_pkg::entry_t rect(int l, int t, int w, int h, int dp);
		resel_pkg::entry_t e;
		e.left = 16'(l);
		e.top = 16'(t);
		e.width = 15'(w);
		e.height = 15'(h);
		e.depth = 8'(dp);
		return e;
	endfunction

	function logic [resel_pkg::S_TDATA_W-1:0] make_item(resel_pkg::entry_t e, int px, int py);
		return {2'b00, 16'(py), 16'(px), e};
	endfunction

	function logic [resel_pkg::S_TDATA_W-1:0] noise_bits();
		logic [127:0] w;
		w = {$urandom, $urandom, $urandom, $urandom};
		return {2'b00, w[101:0]};
	endfunction

	function resel_pkg::entry_t noise_rect();
		logic [resel_pkg::S_TDATA_W-1:0] w;
		w = noise_bits();
		return w[resel_pkg::M_USED_W-1:0];
	endfunction

	function resel_pkg::entry_t rand_rect(int cx, int cy);
		resel_pkg::entry_t e;
		if ($urandom_range(7) == 0) begin
			e = noise_rect();
		end else begin
			e = rect(cx + int'($urandom_range(400)) - 200, cy + int'($urandom_range(400)) - 200,
				$urandom_range(300), $urandom_range(300),
				($urandom_range(1) == 1) ? $urandom_range(3) : $urandom_range(255));
		end
		return e;
	endfunction

	task automatic send_item(logic [resel_pkg::KIND_W-1:0] kind,
		logic [resel_pkg::S_TDATA_W-1:0] data);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= data;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (kind != KIND_UNUSED &&
			!(kind == resel_pkg::KIND_APPEND && sb.fill >= resel_pkg::MAX_ENTRIES)) begin
			live_items++;
		end
		if (kind == resel_pkg::KIND_QUERY) query_count++;
		sb.note_item(kind, data);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.expected_answers.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_snap(logic [resel_pkg::SNAP_W-1:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.write_snap(v);
		snap_writes++;
	endtask

	task automatic run_random(int n);
		int stop_at;
		int cx, cy, nrect, nq;
		resel_pkg::entry_t e;
		stop_at = live_items + n;
		while (live_items < stop_at) begin
			if ($urandom_range(99) < 85) begin
				cx = int'($urandom_range(64000)) - 32000;
				cy = int'($urandom_range(64000)) - 32000;
				send_item(resel_pkg::KIND_CLEAR, noise_bits());
				nrect = $urandom_range(12);
				e = rand_rect(cx, cy);
				for (int i = 0; i < nrect; i++) begin
					// repeated boxes force full ties
					if ($urandom_range(5) != 0) e = rand_rect(cx, cy);
					send_item(resel_pkg::KIND_APPEND, make_item(e, $urandom, $urandom));
				end
				nq = $urandom_range(1, 6);
				for (int i = 0; i < nq; i++) begin
					if ($urandom_range(9) == 0) begin
						send_item(resel_pkg::KIND_QUERY, noise_bits());
					end else begin
						send_item(resel_pkg::KIND_QUERY, make_item(noise_rect(),
							cx + int'($urandom_range(800)) - 400,
							cy + int'($urandom_range(800)) - 400));
					end
				end
			end else begin
				send_item(2'($urandom_range(3)), noise_bits());
			end
		end
	endtask

	initial begin
		logic [resel_pkg::SNAP_W-1:0] snap_plan[12];
		snap_plan = '{12'd0, 12'd1, 12'd4095, 12'd0, 12'd10, 12'd4095,
			12'd1, 12'd0, 12'd1, 12'd250, 12'd4095, 12'd0};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, coordinate extremes, ties, edge of snap range
		send_send_directed: begin
			send_item(resel_pkg::KIND_QUERY, make_item(rect(0, 0, 0, 0, 0), 0, 0));
			send_item(resel_pkg::KIND_APPEND,
				make_item(rect(-32768, -32768, 32767, 32767, 255), -1, -1));
			send_item(resel_pkg::KIND_APPEND, make_item(rect(32767, 32767, 0, 0, 0), 0, 0));
			send_item(resel_pkg::KIND_QUERY, make_item(rect(0, 0, 0, 0, 0), -32768, -32768));
			send_item(resel_pkg::KIND_QUERY, make_item(rect(0, 0, 0, 0, 0), 32767, 32767));
			send_item(resel_pkg::KIND_QUERY, make_item(rect(0, 0, 0, 0, 0), 0, 0));
			send_item(resel_pkg::KIND_CLEAR,
				make_item(rect(-1, -1, 32767, 32767, 255), 32767, -32768));
			send_item(resel_pkg::KIND_APPEND, make_item(rect(100, 100, 50, 50, 3), 0, 0));
			send_item(resel_pkg::KIND_APPEND, make_item(rect(100, 100, 50, 50, 7), 0, 0));
			send_item(resel_pkg::KIND_APPEND, make_item(rect(100, 100, 50, 50, 7), 0, 0));
			send_item(resel_pkg::KIND_QUERY, make_item(rect(0, 0, 0, 0, 0), 120, 120));
			send_item(resel_pkg::KIND_QUERY, make_item(rect(0, 0, 0, 0, 0), 160, 120));
			send_item(resel_pkg::KIND_QUERY, make_item(rect(0, 0, 0, 0, 0), 161, 120));
			for (int i = 0; i < 7; i++) begin
				send_item(resel_pkg::KIND_APPEND,
					make_item(rect(-20000 + i * 100, -20000, 10, 10, i), 0, 0));
			end
			// table full: this one must be dropped
			send_item(resel_pkg::KIND_APPEND, make_item(rect(1000, 1000, 0, 0, 255), 0, 0));
			send_item(KIND_UNUSED, make_item(rect(1000, 1000, 0, 0, 255), 1000, 1000));
			send_item(resel_pkg::KIND_QUERY, make_item(rect(0, 0, 0, 0, 0), 1000, 1000));
			send_item(resel_pkg::KIND_QUERY, make_item(rect(0, 0, 0, 0, 0), -19995, -19995));
		end

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 81 : 0;
			recv_idle_pct = (phase == 0) ? 81 : (phase == 1) ? 7 : 0;
			for (int blk = 0; blk < 4; blk++) begin
				drain();
				if (blk == 3 && phase != 0) begin
					write_snap(12'($urandom_range(1, 4095)));
				end else begin
					write_snap(snap_plan[phase * 4 + blk]);
				end
				// long receiver hold-off while queries keep coming
				if (phase == 2 && blk == 1) recv_hold <= 300;
				run_random(110);
			end
		end

		drain();
		repeat (10) @(posedge clk);
		$display("covered %0d live items, %0d queries, %0d snapped answers", live_items,
			query_count, sb.snapped_answers);
		$display("snap distance written %0d times, idle mixes on both streams", snap_writes);
		if (sb.errors == 0 && sb.expected_answers.size() == 0) begin
			$display("rectangle_edge_snap_select_core_tb: done, clean");
		end else begin
			$display("rectangle_edge_snap_select_core_tb: done, errors");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("rectangle_edge_snap_select_core_tb: done, errors");
		$finish;
	end

endmodule
